@@ rtl/core/box_track_clip_and_contain_defines.svh @@
// Assertion macros for the box track clip and contain block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BOX_TRACK_CLIP_AND_CONTAIN_DEFINES_SVH
`define BOX_TRACK_CLIP_AND_CONTAIN_DEFINES_SVH

`ifndef ASSERT_OFF
// Antecedent holds at an edge, so the consequent must hold at the same edge
`define BCTC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bctc assertion failed");
// Condition must never hold
`define BCTC_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("bctc assertion failed");
`else
`define BCTC_ASSERT_IMPLY(lbl, ante, cons)
`define BCTC_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ rtl/core/bctc_pkg.sv @@
// ----------------------------------------------------------------------------
// bctc_pkg
// Shared constants and codes for the box track clip and contain block.
// ----------------------------------------------------------------------------
`default_nettype none

package bctc_pkg;

	// Default coordinate width (Q23.8 mm) and direction fraction bits
	localparam int COORD_WIDTH_DEF   = 32;
	localparam int DIR_FRAC_BITS_DEF = 14;

	// Direction components are Q1.14 in a fixed 16-bit field
	localparam int DIR_WIDTH = 16;

	// Track length in half units per unit direction: 20 m * 1000 * 256 * 2
	localparam int TRACK_HALF_SCALE = 10240000;
	localparam int SCALE_WIDTH      = 24;

	// Configuration register index
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIZE_X   = 3'd0,
		CFG_SIZE_Y   = 3'd1,
		CFG_SIZE_Z   = 3'd2,
		CFG_CENTER_X = 3'd3,
		CFG_CENTER_Y = 3'd4,
		CFG_CENTER_Z = 3'd5
	} cfg_reg_t;

	// Request codes
	localparam logic [1:0] REQ_REL_CROSS = 2'd0;
	localparam logic [1:0] REQ_ABS_CROSS = 2'd1;
	localparam logic [1:0] REQ_REL_CONT  = 2'd2;
	localparam logic [1:0] REQ_ABS_CONT  = 2'd3;

	// View codes
	localparam logic [1:0] VIEW_SIDE = 2'd0;
	localparam logic [1:0] VIEW_TOP  = 2'd1;

	// Reset value of the box size registers
	localparam int SIZE_RESET = 256;

endpackage

`default_nettype wire

@@ rtl/core/bctc_if.sv @@
// ----------------------------------------------------------------------------
// bctc_if
// Channel interfaces: request items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bctc_req_if #(
	parameter int COORD_WIDTH = bctc_pkg::COORD_WIDTH_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            req_type;
	logic [1:0]                            view;
	logic signed [COORD_WIDTH-1:0]         pos_x;
	logic signed [COORD_WIDTH-1:0]         pos_y;
	logic signed [COORD_WIDTH-1:0]         pos_z;
	logic signed [bctc_pkg::DIR_WIDTH-1:0] dir_x;
	logic signed [bctc_pkg::DIR_WIDTH-1:0] dir_y;
	logic signed [bctc_pkg::DIR_WIDTH-1:0] dir_z;

	modport source (output valid, req_type, view, pos_x, pos_y, pos_z,
		dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, req_type, view, pos_x, pos_y, pos_z,
		dir_x, dir_y, dir_z, output ready);
endinterface

interface bctc_res_if #(
	parameter int COORD_WIDTH = bctc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [COORD_WIDTH-1:0] cross_a;
	logic signed [COORD_WIDTH-1:0] cross_b;
	logic                          view_error;

	modport source (output valid, hit, cross_a, cross_b, view_error, input ready);
	modport sink (input valid, hit, cross_a, cross_b, view_error, output ready);
endinterface

interface bctc_cfg_if #(
	parameter int COORD_WIDTH = bctc_pkg::COORD_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic [bctc_pkg::CFG_IDX_W-1:0] index;
	logic [COORD_WIDTH-1:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/box_track_clip_and_contain.sv @@
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits at the output register.
// Depth is set by the crossing divider, one quotient bit per stage.
// Reset: pipeline valids clear, box sizes return to 256, centres to 0.
`default_nettype none
`include "box_track_clip_and_contain_defines.svh"

// ----------------------------------------------------------------------------
// box_track_clip_and_contain
// Point containment and first edge crossing of a projected track against a
// box held in registers. Pipeline: offsets, edge setup, products, edge pick,
// crossing divider, output.
// ----------------------------------------------------------------------------

module box_track_clip_and_contain #(
	parameter int COORD_WIDTH   = bctc_pkg::COORD_WIDTH_DEF,
	parameter int DIR_FRAC_BITS = bctc_pkg::DIR_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bctc_req_if.sink   req,
	bctc_res_if.source res,
	bctc_cfg_if.sink   cfg
);

	localparam int CW   = COORD_WIDTH;
	localparam int SW   = CW - 1;
	localparam int STW  = CW + 1;
	localparam int DIRW = bctc_pkg::DIR_WIDTH;
	localparam int MW   = DIRW + bctc_pkg::SCALE_WIDTH + 1;
	localparam int DW   = DIRW + bctc_pkg::SCALE_WIDTH - DIR_FRAC_BITS;
	localparam int DDW  = DW + 1;
	localparam int LBW  = DW + 2;
	localparam int EW   = CW + 3;
	localparam int XW   = ((EW > LBW) ? EW : LBW) + 1;
	localparam int PW   = 2 * DW + 3;
	localparam int NW   = 2 * DW + 2;
	localparam int QB   = DW + 1;
	localparam int DENW = DW + 1;
	localparam int RW   = ((CW > DW) ? CW : DW) + 4;

	localparam logic signed [MW-1:0] SCALE = MW'(bctc_pkg::TRACK_HALF_SCALE);
	localparam logic signed [MW-1:0] RND   = MW'(longint'(1) << (DIR_FRAC_BITS - 1));
	localparam logic signed [XW-1:0] LIM   = XW'(longint'(1) << DW);
	localparam logic signed [RW-1:0] QOFF  = RW'(longint'(1) << DW);
	localparam logic signed [RW-1:0] CMAX  = RW'((longint'(1) << (CW - 1)) - 1);
	localparam logic signed [RW-1:0] CMIN  = -CMAX - RW'(1);

	typedef struct packed {
		logic                  ok;
		logic signed [DDW-1:0] n;
		logic signed [DDW-1:0] d;
		logic signed [DW-1:0]  sal;
		logic signed [LBW-1:0] lo;
		logic signed [LBW-1:0] hi;
		logic signed [STW-1:0] stal;
		logic signed [CW-1:0]  e;
	} edge_t;

	typedef struct packed {
		logic                  ok;
		logic signed [PW-1:0]  prod;
		logic signed [PW-1:0]  lod;
		logic signed [PW-1:0]  hid;
		logic signed [DDW-1:0] d;
		logic signed [STW-1:0] stal;
		logic signed [CW-1:0]  e;
	} edge3_t;

	typedef struct packed {
		logic                  contain;
		logic                  cont_hit;
		logic                  verr;
		logic                  found;
		logic                  swap;
		logic                  absm;
		logic                  side;
		logic signed [STW-1:0] stal;
		logic signed [CW-1:0]  across;
	} side_t;

	// Edge setup: position of the edge line along the track, and its span
	function automatic edge_t edge_prep(
		input logic signed [CW-1:0]  e,
		input logic [SW-1:0]         h,
		input logic signed [STW-1:0] st_al,
		input logic signed [STW-1:0] st_ac,
		input logic signed [DW-1:0]  s_al,
		input logic signed [DW-1:0]  s_ac
	);
		logic signed [XW-1:0]  n_w;
		logic signed [XW-1:0]  lo_w;
		logic signed [XW-1:0]  hi_w;
		logic signed [XW-1:0]  h_w;
		logic signed [DDW-1:0] d_w;
		edge_t                 r;
		h_w = XW'($signed({1'b0, h}));
		n_w = XW'(e) - (XW'(st_ac) <<< 1);
		d_w = DDW'(s_ac);
		if (s_ac < 0) begin
			n_w = -n_w;
			d_w = -d_w;
		end
		lo_w = -h_w - (XW'(st_al) <<< 1);
		hi_w = h_w - (XW'(st_al) <<< 1);
		// the quotient never leaves +-2^DW, so clamp the bounds there
		if (lo_w < -LIM) lo_w = -LIM;
		if (lo_w > LIM) lo_w = LIM;
		if (hi_w < -LIM) hi_w = -LIM;
		if (hi_w > LIM) hi_w = LIM;
		r.ok   = (h != '0) && (s_ac != '0) && (n_w >= 0) && (n_w <= XW'(d_w));
		r.n    = DDW'(n_w);
		r.d    = d_w;
		r.sal  = s_al;
		r.lo   = LBW'(lo_w);
		r.hi   = LBW'(hi_w);
		r.stal = st_al;
		r.e    = e;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [SW-1:0]        size_x_q, size_y_q, size_z_q;
	logic signed [CW-1:0] center_x_q, center_y_q, center_z_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= SW'(bctc_pkg::SIZE_RESET);
			size_y_q   <= SW'(bctc_pkg::SIZE_RESET);
			size_z_q   <= SW'(bctc_pkg::SIZE_RESET);
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				bctc_pkg::CFG_SIZE_X:   size_x_q   <= cfg.data[SW-1:0];
				bctc_pkg::CFG_SIZE_Y:   size_y_q   <= cfg.data[SW-1:0];
				bctc_pkg::CFG_SIZE_Z:   size_z_q   <= cfg.data[SW-1:0];
				bctc_pkg::CFG_CENTER_X: center_x_q <= $signed(cfg.data);
				bctc_pkg::CFG_CENTER_Y: center_y_q <= $signed(cfg.data);
				bctc_pkg::CFG_CENTER_Z: center_z_q <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	// Global advance: move when the output register is free or being taken
	logic en;
	logic res_v_q;

	assign en        = !res_v_q || res.ready;
	assign req.ready = en;

	// ------------------------------------------------------------------
	// Stage 1: offsets from the centre and track displacements
	// ------------------------------------------------------------------
	logic                  v_s1;
	logic [1:0]            req_s1, view_s1;
	logic signed [STW-1:0] st_x_s1, st_y_s1, st_z_s1;
	logic signed [DW-1:0]  dsp_x_s1, dsp_y_s1, dsp_z_s1;

	logic                  absm_in;
	logic signed [MW-1:0]  mx_w, my_w, mz_w;

	assign absm_in = (req.req_type == bctc_pkg::REQ_ABS_CROSS) ||
		(req.req_type == bctc_pkg::REQ_ABS_CONT);
	assign mx_w = (MW'(req.dir_x) * SCALE + RND) >>> DIR_FRAC_BITS;
	assign my_w = (MW'(req.dir_y) * SCALE + RND) >>> DIR_FRAC_BITS;
	assign mz_w = (MW'(req.dir_z) * SCALE + RND) >>> DIR_FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1   <= req.req_type;
			view_s1  <= req.view;
			st_x_s1  <= STW'(req.pos_x) - (absm_in ? STW'(center_x_q) : '0);
			st_y_s1  <= STW'(req.pos_y) - (absm_in ? STW'(center_y_q) : '0);
			st_z_s1  <= STW'(req.pos_z) - (absm_in ? STW'(center_z_q) : '0);
			dsp_x_s1 <= DW'(mx_w);
			dsp_y_s1 <= DW'(my_w);
			dsp_z_s1 <= DW'(mz_w);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: containment test, view select, edge setup
	// ------------------------------------------------------------------
	logic  v_s2, contain_s2, cont_hit_s2, verr_s2, absm_s2, side_s2;
	edge_t edge_s2 [4];

	logic                  contain_w, side_w, known_w, cont_w;
	logic [STW-1:0]        mag_x, mag_y, mag_z;
	logic signed [STW-1:0] sa_w, sb_w;
	logic signed [DW-1:0]  da_w, db_w;
	logic [SW-1:0]         ha_w, hb_w;
	logic signed [CW-1:0]  ha_s, hb_s;

	always_comb begin
		contain_w = (req_s1 == bctc_pkg::REQ_REL_CONT) || (req_s1 == bctc_pkg::REQ_ABS_CONT);
		side_w    = (view_s1 == bctc_pkg::VIEW_SIDE);
		known_w   = side_w || (view_s1 == bctc_pkg::VIEW_TOP);
		mag_x     = st_x_s1[STW-1] ? STW'(-st_x_s1) : STW'(st_x_s1);
		mag_y     = st_y_s1[STW-1] ? STW'(-st_y_s1) : STW'(st_y_s1);
		mag_z     = st_z_s1[STW-1] ? STW'(-st_z_s1) : STW'(st_z_s1);
		cont_w    = ({mag_x, 1'b0} < (STW + 1)'(size_x_q)) &&
			({mag_y, 1'b0} < (STW + 1)'(size_y_q)) &&
			({mag_z, 1'b0} < (STW + 1)'(size_z_q));
		sa_w = st_z_s1;
		sb_w = side_w ? st_y_s1 : st_x_s1;
		da_w = dsp_z_s1;
		db_w = side_w ? dsp_y_s1 : dsp_x_s1;
		ha_w = size_z_q;
		hb_w = side_w ? size_y_q : size_x_q;
		ha_s = $signed({1'b0, ha_w});
		hb_s = $signed({1'b0, hb_w});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	// edges in test order: bottom, right, top, left
	always_ff @(posedge clk) begin
		if (en) begin
			contain_s2  <= contain_w;
			cont_hit_s2 <= cont_w;
			verr_s2     <= !contain_w && !known_w;
			absm_s2     <= req_s1[0];
			side_s2     <= side_w;
			edge_s2[0]  <= edge_prep(-hb_s, ha_w, sa_w, sb_w, da_w, db_w);
			edge_s2[1]  <= edge_prep(ha_s, hb_w, sb_w, sa_w, db_w, da_w);
			edge_s2[2]  <= edge_prep(hb_s, ha_w, sa_w, sb_w, da_w, db_w);
			edge_s2[3]  <= edge_prep(-ha_s, hb_w, sb_w, sa_w, db_w, da_w);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: crossing product and scaled span bounds per edge
	// ------------------------------------------------------------------
	logic   v_s3, contain_s3, cont_hit_s3, verr_s3, absm_s3, side_s3;
	edge3_t edge_s3 [4];

	logic signed [DDW+DW-1:0]  prod_w [4];
	logic signed [LBW+DDW-1:0] lod_w  [4];
	logic signed [LBW+DDW-1:0] hid_w  [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod_w[i] = edge_s2[i].n * edge_s2[i].sal;
			lod_w[i]  = edge_s2[i].lo * edge_s2[i].d;
			hid_w[i]  = edge_s2[i].hi * edge_s2[i].d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			contain_s3  <= contain_s2;
			cont_hit_s3 <= cont_hit_s2;
			verr_s3     <= verr_s2;
			absm_s3     <= absm_s2;
			side_s3     <= side_s2;
			for (int i = 0; i < 4; i++) begin
				edge_s3[i].ok   <= edge_s2[i].ok;
				edge_s3[i].prod <= PW'(prod_w[i]);
				edge_s3[i].lod  <= PW'(lod_w[i]);
				edge_s3[i].hid  <= PW'(hid_w[i]);
				edge_s3[i].d    <= edge_s2[i].d;
				edge_s3[i].stal <= edge_s2[i].stal;
				edge_s3[i].e    <= edge_s2[i].e;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: span check, first edge that crosses, divider operands
	// ------------------------------------------------------------------
	logic            v_s4;
	logic [NW-1:0]   num_s4;
	logic [DENW-1:0] den_s4;
	side_t           side_s4;

	logic [3:0]           hit_w;
	logic [1:0]           sel_w;
	edge3_t               es_w;
	logic signed [PW-1:0] num_w;
	logic signed [CW:0]   acr_w;
	side_t                sd_w;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hit_w[i] = edge_s3[i].ok && (edge_s3[i].prod >= edge_s3[i].lod) &&
				(edge_s3[i].prod <= edge_s3[i].hid);
		end
		sel_w = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (hit_w[i]) sel_w = 2'(i);
		end
		es_w  = edge_s3[sel_w];
		// bias keeps the rounded quotient non-negative
		num_w = es_w.prod + PW'(es_w.d) + (PW'(es_w.d) <<< (DW + 1));
		acr_w = ((CW + 1)'(es_w.e) + (CW + 1)'(1)) >>> 1;
		sd_w.contain  = contain_s3;
		sd_w.cont_hit = cont_hit_s3;
		sd_w.verr     = verr_s3;
		sd_w.found    = |hit_w;
		sd_w.swap     = sel_w[0];
		sd_w.absm     = absm_s3;
		sd_w.side     = side_s3;
		sd_w.stal     = es_w.stal;
		sd_w.across   = CW'(acr_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= NW'(num_w);
			den_s4  <= {es_w.d[DW-1:0], 1'b0};
			side_s4 <= sd_w;
		end
	end

	// ------------------------------------------------------------------
	// Crossing divider: floor((prod + d) / 2d) plus bias
	// ------------------------------------------------------------------
	logic                     dv_valid;
	logic [QB-1:0]            dv_quo;
	logic [$bits(side_t)-1:0] dv_side_w;
	side_t                    dv_side;

	bctc_div #(
		.NW     (NW),
		.DENW   (DENW),
		.QB     (QB),
		.SIDE_W ($bits(side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (num_s4),
		.in_den    (den_s4),
		.in_side   (side_s4),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side_w)
	);

	assign dv_side = dv_side_w;

	// ------------------------------------------------------------------
	// Output: shift back by the centre, saturate, hold for the sink
	// ------------------------------------------------------------------
	logic                 hit_q, verr_q;
	logic signed [CW-1:0] cross_a_q, cross_b_q;

	logic signed [RW-1:0] along_w, ra_w, rb_w, ca_w, cb_w, fa_w, fb_w;
	logic signed [CW-1:0] sat_a_w, sat_b_w;

	always_comb begin
		along_w = RW'(dv_side.stal) + (RW'($signed({1'b0, dv_quo})) - QOFF);
		ra_w    = dv_side.swap ? RW'(dv_side.across) : along_w;
		rb_w    = dv_side.swap ? along_w : RW'(dv_side.across);
		ca_w    = dv_side.absm ? RW'(center_z_q) : '0;
		cb_w    = dv_side.absm ? (dv_side.side ? RW'(center_y_q) : RW'(center_x_q)) : '0;
		fa_w    = ra_w + ca_w;
		fb_w    = rb_w + cb_w;
		if (fa_w > CMAX) fa_w = CMAX;
		if (fa_w < CMIN) fa_w = CMIN;
		if (fb_w > CMAX) fb_w = CMAX;
		if (fb_w < CMIN) fb_w = CMIN;
		sat_a_w = CW'(fa_w);
		sat_b_w = CW'(fb_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (en) begin
			res_v_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_side.contain) begin
				hit_q     <= dv_side.cont_hit;
				verr_q    <= 1'b0;
				cross_a_q <= '0;
				cross_b_q <= '0;
			end else if (dv_side.verr) begin
				hit_q     <= 1'b0;
				verr_q    <= 1'b1;
				cross_a_q <= '0;
				cross_b_q <= '0;
			end else begin
				hit_q     <= dv_side.found;
				verr_q    <= 1'b0;
				cross_a_q <= dv_side.found ? sat_a_w : '0;
				cross_b_q <= dv_side.found ? sat_b_w : '0;
			end
		end
	end

	assign res.valid      = res_v_q;
	assign res.hit        = hit_q;
	assign res.cross_a    = cross_a_q;
	assign res.cross_b    = cross_b_q;
	assign res.view_error = verr_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BCTC_ASSERT_NEVER(a_err_and_hit, res_v_q && verr_q && hit_q)
	`BCTC_ASSERT_IMPLY(a_miss_zero, res_v_q && !hit_q, cross_a_q == '0 && cross_b_q == '0)
	`BCTC_ASSERT_IMPLY(a_stall_hold, $past(res_v_q && !res.ready), res_v_q && $stable(cross_a_q))

endmodule

`default_nettype wire

@@ rtl/core/bctc_div.sv @@
// ----------------------------------------------------------------------------
// bctc_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside each item. Numerator must be below den << QB.
// ----------------------------------------------------------------------------
`default_nettype none

module bctc_div #(
	parameter int NW     = 54,
	parameter int DENW   = 27,
	parameter int QB     = 27,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NW-1:0]     in_num,
	input  wire logic [DENW-1:0]   in_den,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [QB-1:0]          out_quo,
	output logic [SIDE_W-1:0]      out_side
);

	logic              vld_s  [QB];
	logic [NW-1:0]     rem_s  [QB];
	logic [DENW-1:0]   den_s  [QB];
	logic [QB-1:0]     quo_s  [QB];
	logic [SIDE_W-1:0] side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic              vld_i;
		logic [NW-1:0]     rem_i;
		logic [DENW-1:0]   den_i;
		logic [QB-1:0]     quo_i;
		logic [SIDE_W-1:0] side_i;
		logic [NW-1:0]     dsh;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_i  = in_valid;
			assign rem_i  = in_num;
			assign den_i  = in_den;
			assign quo_i  = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign den_i  = den_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign side_i = side_s[k-1];
		end

		// trial subtract of the shifted divisor
		assign dsh = NW'(den_i) << (QB - 1 - k);
		assign ge  = (rem_i >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (rem_i - dsh) : rem_i;
				quo_s[k]  <= ge ? (quo_i | (QB'(1) << (QB - 1 - k))) : quo_i;
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign out_quo   = quo_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

`default_nettype wire
